// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: record layout,
// result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

   // queue geometry
   localparam int DEPTH       = 16;
   localparam int SUBJECTS    = 5;
   localparam int FIELD_MARKS = 5;
   localparam int USED_MARKS  = (SUBJECTS < FIELD_MARKS) ? SUBJECTS : FIELD_MARKS;

   // field widths
   localparam int ROLL_W = 16;
   localparam int MARK_W = 7;
   localparam int KEY_W  = 9;
   localparam int SUM_W  = MARK_W + $clog2(FIELD_MARKS + 1);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 5;

   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

   // operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // result codes
   typedef enum logic [1:0] {
      RES_ENQUEUED  = 2'd0,
      RES_DEQUEUED  = 2'd1,
      RES_UNDERFLOW = 2'd2,
      RES_OVERFLOW  = 2'd3
   } res_code_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // one stored record
   typedef struct packed {
      logic [ROLL_W-1:0]                  roll;
      logic [FIELD_MARKS-1:0][MARK_W-1:0] mark;
      logic [KEY_W-1:0]                   key;
   } rec_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         execute;
      logic         do_enq;
      logic         do_deq;
      res_code_type code;
   } spq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_deq;
      logic empty;
      logic full;
   } spq_sts_type;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the sorted priority queue: takes one request beat, issues the
// store operation once the result register is free, and owns rsp_valid.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  spq_sts_type sts,
   output spq_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.do_enq  = 1'b0;
      cmd.do_deq  = 1'b0;
      cmd.code    = RES_ENQUEUED;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
               if (sts.op_deq) begin
                  if (sts.empty) begin
                     cmd.code = RES_UNDERFLOW;
                  end else begin
                     cmd.code   = RES_DEQUEUED;
                     cmd.do_deq = 1'b1;
                  end
               end else begin
                  if (sts.full) begin
                     cmd.code = RES_OVERFLOW;
                  end else begin
                     cmd.code   = RES_ENQUEUED;
                     cmd.do_enq = 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result beat valid: set on execute, cleared when taken
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a finished result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (state_ff == S_EXEC) && out_free)
      else $error("result register overwritten");

   // an execute always leaves a result beat pending
   a_exec_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("execute without result beat");

   // store writes only when the store can take them
   a_enq_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_enq |-> !sts.full && !sts.op_deq)
      else $error("enqueue into full store");

   a_deq_data: assert property (@(posedge clock) disable iff (reset)
      cmd.do_deq |-> !sts.empty && sts.op_deq)
      else $error("dequeue from empty store");
`endif

endmodule

// ===== rtl/core/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Request capture with key adder, a shifting row of sorted record cells
// (cell 0 holds the front record, the next to be dequeued) and the result register.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  spq_cmd_type         cmd,
   output spq_sts_type         sts,
   input  logic                req_op,
   input  logic [ROLL_W-1:0]   req_roll,
   input  logic [MARK_W-1:0]   req_mark_a,
   input  logic [MARK_W-1:0]   req_mark_b,
   input  logic [MARK_W-1:0]   req_mark_c,
   input  logic [MARK_W-1:0]   req_mark_d,
   input  logic [MARK_W-1:0]   req_mark_e,
   output logic [1:0]          rsp_status,
   output logic [ROLL_W-1:0]   rsp_out_roll,
   output logic [MARK_W-1:0]   rsp_out_mark_a,
   output logic [MARK_W-1:0]   rsp_out_mark_b,
   output logic [MARK_W-1:0]   rsp_out_mark_c,
   output logic [MARK_W-1:0]   rsp_out_mark_d,
   output logic [MARK_W-1:0]   rsp_out_mark_e,
   output logic [KEY_W-1:0]    rsp_score_sum,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   logic [FIELD_MARKS-1:0][MARK_W-1:0] raw_mark;
   logic [FIELD_MARKS-1:0][MARK_W-1:0] used_mark;
   logic [SUM_W-1:0]                   mark_sum;
   rec_type                            new_in;
   rec_type                            new_ff;
   logic                               op_ff;
   rec_type                            cell_ff [DEPTH];
   rec_type                            cell_in [DEPTH];
   logic [DEPTH-1:0]                   lt;
   logic [CNT_W-1:0]                   count_ff, count_in;
   res_code_type                       code_ff;
   rec_type                            out_ff;
   logic [OCC_W-1:0]                   occ_ff;

   assign raw_mark = {req_mark_e, req_mark_d, req_mark_c, req_mark_b, req_mark_a};

   // unused subjects are dropped and read back as zero
   always_comb begin
      for (int i = 0; i < FIELD_MARKS; i++) begin
         used_mark[i] = (i < USED_MARKS) ? raw_mark[i] : '0;
      end
   end

   // key adder with saturation
   always_comb begin
      mark_sum = '0;
      for (int i = 0; i < FIELD_MARKS; i++) begin
         mark_sum = mark_sum + SUM_W'(used_mark[i]);
      end
      new_in.roll = req_roll;
      new_in.mark = used_mark;
      if (mark_sum > SUM_W'(KEY_MAX)) begin
         new_in.key = KEY_MAX;
      end else begin
         new_in.key = mark_sum[KEY_W-1:0];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_ff <= new_in;
         op_ff  <= req_op;
      end
   end

   assign sts.op_deq = (op_ff == OP_DEQUEUE);
   assign sts.empty  = (count_ff == '0);
   assign sts.full   = (count_ff == CNT_W'(DEPTH));

   // per-cell compare: held record with lower key than the new one
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         lt[j] = (CNT_W'(j) < count_ff) && (cell_ff[j].key < new_ff.key);
      end
   end

   // cell row: insert shifts the higher records up, dequeue shifts all down
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      rec_type below;
      rec_type above;
      logic    below_lt;

      if (j == 0) begin : g_first
         assign below    = new_ff;
         assign below_lt = 1'b1;
      end else begin : g_rest
         assign below    = cell_ff[j-1];
         assign below_lt = lt[j-1];
      end

      if (j == DEPTH - 1) begin : g_last
         assign above = cell_ff[j];
      end else begin : g_mid
         assign above = cell_ff[j+1];
      end

      always_comb begin
         cell_in[j] = cell_ff[j];
         if (cmd.do_enq) begin
            if (lt[j]) begin
               cell_in[j] = cell_ff[j];
            end else if (below_lt) begin
               cell_in[j] = new_ff;
            end else begin
               cell_in[j] = below;
            end
         end else if (cmd.do_deq) begin
            cell_in[j] = above;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[j] <= cell_in[j];
      end
   end

   // record count
   always_comb begin
      count_in = count_ff;
      if (cmd.do_enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.do_deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         code_ff <= cmd.code;
         occ_ff  <= OCC_W'(count_in);
         if (cmd.do_deq) begin
            out_ff <= cell_ff[0];
         end else begin
            out_ff <= '0;
         end
      end
   end

   assign rsp_status     = code_ff;
   assign rsp_out_roll   = out_ff.roll;
   assign rsp_out_mark_a = out_ff.mark[0];
   assign rsp_out_mark_b = out_ff.mark[1];
   assign rsp_out_mark_c = out_ff.mark[2];
   assign rsp_out_mark_d = out_ff.mark[3];
   assign rsp_out_mark_e = out_ff.mark[4];
   assign rsp_score_sum  = out_ff.key;
   assign rsp_occupancy  = occ_ff;

`ifndef SYNTHESIS
   // count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record count above depth");

   // an insert grows the count by exactly one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_enq |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   // results other than a dequeue carry a zero record
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && !cmd.do_deq |=> rsp_out_roll == '0 && rsp_score_sum == '0)
      else $error("non-dequeue result with record data");
`endif

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// A request beat is captured in the request register; its result beat is registered
// when the operation executes, once the result register is free. Requests do not overlap;
// a stalled result beat holds the next operation in its execute cycle.
// Insert and dequeue each update the whole shifting cell row at once, whatever the count.
// Reset (synchronous, active high) empties the queue by clearing the record count;
// the cells themselves are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of records ordered by ascending mark sum; dequeue
// removes the lowest key, newest first among equal keys.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [ROLL_W-1:0]   req_roll,
   input  logic [MARK_W-1:0]   req_mark_a,
   input  logic [MARK_W-1:0]   req_mark_b,
   input  logic [MARK_W-1:0]   req_mark_c,
   input  logic [MARK_W-1:0]   req_mark_d,
   input  logic [MARK_W-1:0]   req_mark_e,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ROLL_W-1:0]   rsp_out_roll,
   output logic [MARK_W-1:0]   rsp_out_mark_a,
   output logic [MARK_W-1:0]   rsp_out_mark_b,
   output logic [MARK_W-1:0]   rsp_out_mark_c,
   output logic [MARK_W-1:0]   rsp_out_mark_d,
   output logic [MARK_W-1:0]   rsp_out_mark_e,
   output logic [KEY_W-1:0]    rsp_score_sum,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   spq_cmd_type cmd;
   spq_sts_type sts;

   // sequencer
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // record store and result register
   spq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_roll       (req_roll),
      .req_mark_a     (req_mark_a),
      .req_mark_b     (req_mark_b),
      .req_mark_c     (req_mark_c),
      .req_mark_d     (req_mark_d),
      .req_mark_e     (req_mark_e),
      .rsp_status     (rsp_status),
      .rsp_out_roll   (rsp_out_roll),
      .rsp_out_mark_a (rsp_out_mark_a),
      .rsp_out_mark_b (rsp_out_mark_b),
      .rsp_out_mark_c (rsp_out_mark_c),
      .rsp_out_mark_d (rsp_out_mark_d),
      .rsp_out_mark_e (rsp_out_mark_e),
      .rsp_score_sum  (rsp_score_sum),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule
